// ----- hw/rtl/fcpa_pkg.sv -----
package fcpa_pkg;

  // Field and register widths
  localparam int OFF_W    = 26;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;
  localparam int CBYTES_W = 17;
  localparam int CCOUNT_W = 11;
  localparam int CADDR_W  = 1;
  localparam int SIZE_W   = 17;

  // Chunk size limits
  localparam int MIN_CHUNK_BYTES = 8;
  localparam int MAX_CHUNK_BYTES = 65536;

  // Defaults for the top-level parameters
  localparam int POOL_CHUNKS_DEF = 1024;
  localparam int ALIGN_BYTES_DEF = 8;

  // Register reset values
  localparam logic [CBYTES_W-1:0] CHUNK_BYTES_RST = 17'd8;
  localparam logic [CCOUNT_W-1:0] CHUNK_COUNT_RST = 11'd1024;

  // Configuration register indexes
  localparam logic [CADDR_W-1:0] CFG_CHUNK_BYTES = 1'b0;
  localparam logic [CADDR_W-1:0] CFG_CHUNK_COUNT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOT_POOL = 3'd2,
    ST_NULL     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    calc_q;
    logic    calc_size;
    logic    pop;
    logic    mul;
    logic    calc_limit;
    logic    div_init;
    logic    div_step;
    logic    push;
    logic    walk_init;
    logic    walk_step;
    logic    fill_done;
    logic    set_res;
    status_t res_code;
    logic    load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t item_cmd;
    logic pvalid;
    logic count_zero;
    logic n_zero;
    logic off_ge_limit;
    logic rem_nonzero;
    logic count_ge_n;
    logic div_last;
    logic walk_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- hw/rtl/fcpa_ctrl.sv -----
module fcpa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fcpa_pkg::ctrl_stat_t stat,
  output fcpa_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SIZE  = 11'b00000000010,
    S_SCALE = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_LIMIT = 11'b00000010000,
    S_CHECK = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_TEST  = 11'b00010000000,
    S_WALK  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing and datapath commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = fcpa_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.calc_q = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.calc_size = 1'b1;
        case (stat.item_cmd)
          fcpa_pkg::CMD_ALLOC: begin
            if (stat.count_zero) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = fcpa_pkg::ST_EMPTY;
              state_next   = S_OUT;
            end else begin
              cmd.pop    = 1'b1;
              state_next = S_MUL;
            end
          end
          fcpa_pkg::CMD_FREE: begin
            if (!stat.pvalid) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = fcpa_pkg::ST_NULL;
              state_next   = S_OUT;
            end else begin
              state_next = S_LIMIT;
            end
          end
          fcpa_pkg::CMD_RESET: begin
            if (stat.n_zero) begin
              cmd.fill_done = 1'b1;
              cmd.set_res   = 1'b1;
              state_next    = S_OUT;
            end else begin
              cmd.walk_init = 1'b1;
              state_next    = S_WALK;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            state_next  = S_OUT;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OUT;
      end
      S_LIMIT: begin
        cmd.calc_limit = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (stat.off_ge_limit) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = fcpa_pkg::ST_NOT_POOL;
          state_next   = S_OUT;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        cmd.set_res = 1'b1;
        state_next  = S_OUT;
        if (stat.rem_nonzero) begin
          cmd.res_code = fcpa_pkg::ST_NOT_POOL;
        end else if (stat.count_ge_n) begin
          cmd.res_code = fcpa_pkg::ST_OVERFLOW;
        end else begin
          cmd.push = 1'b1;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          cmd.fill_done = 1'b1;
          cmd.set_res   = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/fcpa_dp.sv -----
module fcpa_dp #(
  parameter int POOL_CHUNKS = fcpa_pkg::POOL_CHUNKS_DEF,
  parameter int ALIGN_BYTES = fcpa_pkg::ALIGN_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [fcpa_pkg::CADDR_W-1:0]        cfg_addr,
  input  logic [fcpa_pkg::CBYTES_W-1:0]       cfg_wdata,
  // incoming item fields
  input  fcpa_pkg::cmd_t                      in_command,
  input  logic                                in_pvalid,
  input  logic [fcpa_pkg::OFF_W-1:0]          in_offset,
  // result register
  input  logic                                out_ready,
  output logic                                out_valid,
  output fcpa_pkg::status_t                   out_status,
  output logic [fcpa_pkg::OFF_W-1:0]          out_offset,
  // controller link
  input  fcpa_pkg::ctrl_cmd_t                 cmd,
  output fcpa_pkg::ctrl_stat_t                stat
);

  localparam int OW   = fcpa_pkg::OFF_W;
  localparam int SZW  = fcpa_pkg::SIZE_W;
  localparam int IW   = (POOL_CHUNKS > 1) ? $clog2(POOL_CHUNKS) : 1;
  localparam int CW   = $clog2(POOL_CHUNKS + 1);
  localparam int SW   = (IW > 1) ? $clog2(IW) : 1;
  localparam int LW   = CW + SZW;
  localparam int CMPW = LW + OW;
  localparam int DW   = OW + IW;
  localparam int PW   = IW + SZW;
  // Size rounding: floor(x / ALIGN_BYTES) as (x * RM) >> RK, exact for x below 2^18
  localparam int XW   = 18;
  localparam int RK   = 26;
  localparam int RMW  = 27;
  localparam int QPW  = XW + RMW;
  localparam int RM   = ((1 << RK) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int SPW  = 24;
  localparam int CAP  = (fcpa_pkg::MAX_CHUNK_BYTES / ALIGN_BYTES) * ALIGN_BYTES;

  // Configuration registers
  logic [fcpa_pkg::CBYTES_W-1:0] chunk_bytes;
  logic [fcpa_pkg::CCOUNT_W-1:0] chunk_count;

  // Item and work registers
  fcpa_pkg::cmd_t    item_cmd;
  logic              item_pvalid;
  logic [OW-1:0]     item_off;
  logic [XW-1:0]     q;
  logic [SZW-1:0]    size;
  logic [LW-1:0]     limit;
  logic [OW-1:0]     rem;
  logic [IW-1:0]     quot;
  logic [SW-1:0]     step;
  logic [IW-1:0]     walk_idx;
  logic [IW-1:0]     rd_data;
  logic [CW-1:0]     count;
  fcpa_pkg::status_t res_status;
  logic [OW-1:0]     res_offset;

  logic [IW-1:0]     mem [POOL_CHUNKS];

  logic [SZW-1:0]    s_clamp;
  logic [XW-1:0]     sx;
  logic [QPW-1:0]    q_prod;
  logic [SPW-1:0]    size_pre;
  logic [CW-1:0]     n_eff;
  logic [CW-1:0]     cnt_dec;
  logic [DW-1:0]     trial;
  logic              trial_ok;
  logic [PW-1:0]     prod;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [IW-1:0]     mem_wdata;

  // Effective chunk size and count
  assign s_clamp  = (chunk_bytes < SZW'(fcpa_pkg::MIN_CHUNK_BYTES)) ?
                    SZW'(fcpa_pkg::MIN_CHUNK_BYTES) : chunk_bytes;
  assign sx       = XW'(s_clamp) + XW'(ALIGN_BYTES - 1);
  assign q_prod   = QPW'(sx) * QPW'(RM);
  assign size_pre = SPW'(q) * SPW'(ALIGN_BYTES);
  assign n_eff    = (32'(chunk_count) > 32'(POOL_CHUNKS)) ? CW'(POOL_CHUNKS) : CW'(chunk_count);
  assign cnt_dec  = count - CW'(1);

  // Restoring divider trial subtract, one quotient bit per step
  assign trial    = DW'(size) << step;
  assign trial_ok = (DW'(rem) >= trial);

  assign prod     = PW'(rd_data) * PW'(size);

  // Stack write port: fill walk or free push
  assign mem_we    = cmd.push | cmd.walk_step;
  assign mem_waddr = cmd.walk_step ? walk_idx : count[IW-1:0];
  assign mem_wdata = cmd.walk_step ? walk_idx : quot;

  // Status back to the controller
  assign stat.item_cmd     = item_cmd;
  assign stat.pvalid       = item_pvalid;
  assign stat.count_zero   = (count == '0);
  assign stat.n_zero       = (n_eff == '0);
  assign stat.off_ge_limit = (CMPW'(item_off) >= CMPW'(limit));
  assign stat.rem_nonzero  = (rem != '0);
  assign stat.count_ge_n   = (count >= n_eff);
  assign stat.div_last     = (step == '0);
  assign stat.walk_last    = ((CW'(walk_idx) + CW'(1)) == n_eff);
  assign stat.out_free     = !out_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= fcpa_pkg::CHUNK_BYTES_RST;
      chunk_count <= fcpa_pkg::CHUNK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        fcpa_pkg::CFG_CHUNK_BYTES: chunk_bytes <= cfg_wdata;
        fcpa_pkg::CFG_CHUNK_COUNT: chunk_count <= cfg_wdata[fcpa_pkg::CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stack depth counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.pop) begin
      count <= cnt_dec;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.fill_done) begin
      count <= n_eff;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_offset <= res_offset;
    end
  end

  // Free stack memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.pop) begin
      rd_data <= mem[cnt_dec[IW-1:0]];
    end
  end

  // Item capture, size, bounds, divider, walk and result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd    <= in_command;
      item_pvalid <= in_pvalid;
      item_off    <= in_offset;
    end
    if (cmd.calc_q) begin
      q <= XW'(q_prod >> RK);
    end
    if (cmd.calc_size) begin
      size <= (size_pre > SPW'(CAP)) ? SZW'(CAP) : SZW'(size_pre);
    end
    if (cmd.calc_limit) begin
      limit <= LW'(n_eff) * LW'(size);
    end
    if (cmd.div_init) begin
      rem  <= item_off;
      quot <= '0;
      step <= SW'(IW - 1);
    end else if (cmd.div_step) begin
      if (trial_ok) begin
        rem        <= OW'(DW'(rem) - trial);
        quot[step] <= 1'b1;
      end
      step <= step - SW'(1);
    end
    if (cmd.walk_init) begin
      walk_idx <= '0;
    end else if (cmd.walk_step) begin
      walk_idx <= walk_idx + IW'(1);
    end
    if (cmd.mul) begin
      res_status <= fcpa_pkg::ST_OK;
      res_offset <= OW'(prod);
    end else if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_offset <= '0;
    end
  end

endmodule

// ----- hw/rtl/fixed_chunk_pool_allocator_top.sv -----
// Free checks the offset against the region and divides it, one quotient bit a cycle.
// One item in work at a time; the next is taken the cycle after its result is loaded into
//   the output register (a stalled result holds it off).
// Reset (rst, synchronous) empties the stack and sets chunk_bytes 8, chunk_count 1024.
module fixed_chunk_pool_allocator_top #(
  parameter int POOL_CHUNKS = fcpa_pkg::POOL_CHUNKS_DEF,
  parameter int ALIGN_BYTES = fcpa_pkg::ALIGN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fcpa_pkg::CADDR_W-1:0]   cfg_addr,
  input  logic [fcpa_pkg::CBYTES_W-1:0]  cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // free_offset[25:0], zero pad
  input  logic [2:0]                     s_axis_tuser,  // command[1:0], pointer_valid[2]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // alloc_offset[25:0], zero pad
  output logic [2:0]                     m_axis_tuser   // status[2:0]
);

  fcpa_pkg::ctrl_cmd_t            cmd;
  fcpa_pkg::ctrl_stat_t           stat;
  fcpa_pkg::status_t              out_status;
  logic [fcpa_pkg::OFF_W-1:0]     out_offset;

  fcpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcpa_dp #(
    .POOL_CHUNKS (POOL_CHUNKS),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_command (fcpa_pkg::cmd_t'(s_axis_tuser[1:0])),
    .in_pvalid  (s_axis_tuser[2]),
    .in_offset  (s_axis_tdata[fcpa_pkg::OFF_W-1:0]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_offset (out_offset),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign m_axis_tdata = 32'(out_offset);
  assign m_axis_tuser = out_status;

endmodule
